// ===== design/hmbp_pkg.sv =====
// ============================================================================
// hmbp_pkg
// Shared types, constants and microcode for the binaural head-model panner.
// ============================================================================
package hmbp_pkg;

  // Default widths
  localparam int unsigned SampleBitsDef   = 24;
  localparam int unsigned CoefFracBitsDef = 16;

  // Register file: four coefficients per ear, left ear first
  localparam int unsigned NumRegs   = 8;
  localparam int unsigned RegIdxW   = 3;
  localparam int unsigned PcW       = 3;

  // Multiplier operand (sample side)
  typedef enum logic [1:0] {
    OPD_X  = 2'd0,  // current input
    OPD_XP = 2'd1,  // previous input
    OPD_HP = 2'd2,  // previous shadow value
    OPD_HY = 2'd3   // new shadow value minus previous output
  } opd_sel_e;

  // Coefficient slot within one ear
  typedef enum logic [1:0] {
    CF_B0 = 2'd0,
    CF_B1 = 2'd1,
    CF_A1 = 2'd2,
    CF_G  = 2'd3
  } coef_sel_e;

  // Accumulator operation
  typedef enum logic [2:0] {
    ACC_HOLD = 3'd0,
    ACC_LOAD = 3'd1,  // acc = product
    ACC_ADD  = 3'd2,  // acc += product
    ACC_SUB  = 3'd3,  // acc -= product
    ACC_HP   = 3'd4   // acc = previous shadow scaled to coefficient fraction
  } acc_op_e;

  // One control word of the step program
  typedef struct packed {
    opd_sel_e  opd;
    coef_sel_e coef;
    acc_op_e   acc_op;
    logic      take_h;  // round, saturate and hold the shadow value
    logic      take_y;  // round, saturate and commit the ear's history
    logic      last;    // end of the ear's program
  } uword_t;

  // Sequencer to datapath control
  typedef struct packed {
    logic   load_x;  // capture the accepted sample
    logic   step;    // execute the current control word
    logic   ear;     // 0 left, 1 right
    uword_t uw;
  } dp_ctrl_t;

  // Step program for one ear (run once per ear)
  function automatic uword_t ucode_rom(input logic [PcW-1:0] pc);
    uword_t w;
    w = '{opd: OPD_X, coef: CF_B0, acc_op: ACC_HOLD, take_h: 1'b0, take_y: 1'b0,
          last: 1'b0};
    case (pc)
      3'd0: begin
        w.opd = OPD_X;  w.coef = CF_B0; w.acc_op = ACC_LOAD;
      end
      3'd1: begin
        w.opd = OPD_XP; w.coef = CF_B1; w.acc_op = ACC_ADD;
      end
      3'd2: begin
        w.opd = OPD_HP; w.coef = CF_A1; w.acc_op = ACC_SUB;
      end
      3'd3: begin
        w.acc_op = ACC_HP; w.take_h = 1'b1;
      end
      3'd4: begin
        w.opd = OPD_HY; w.coef = CF_G;  w.acc_op = ACC_ADD;
      end
      3'd5: begin
        w.take_y = 1'b1; w.last = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== design/hmbp_datapath.sv =====
// ============================================================================
// hmbp_datapath
// Shared multiply-accumulate datapath, coefficient registers and per-ear
// filter history, fed one sequencer control word per cycle unless stalled.
// ============================================================================
module hmbp_datapath
  import hmbp_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS    = SampleBitsDef,
  parameter int unsigned COEF_FRAC_BITS = CoefFracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [RegIdxW-1:0]            cfg_idx_i,
  input  logic [COEF_FRAC_BITS+1:0]     cfg_data_i,
  input  dp_ctrl_t                      ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic signed [SAMPLE_BITS-1:0] result_o
);

  localparam int unsigned CoefW = COEF_FRAC_BITS + 2;
  localparam int unsigned ProdW = CoefW + SAMPLE_BITS + 1;
  localparam int unsigned AccW  = CoefW + SAMPLE_BITS + 2;

  localparam logic signed [AccW-1:0] RndHalf =
    {{(AccW-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
  localparam logic signed [AccW-1:0] SatMax =
    {{(AccW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [AccW-1:0] SatMin = ~SatMax;
  localparam logic [CoefW-1:0] CoefOne =
    {2'b01, {COEF_FRAC_BITS{1'b0}}};

  logic signed [CoefW-1:0]       coef_q [NumRegs];
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [SAMPLE_BITS-1:0] h_q;
  logic signed [SAMPLE_BITS-1:0] xp_q [2];
  logic signed [SAMPLE_BITS-1:0] hp_q [2];
  logic signed [SAMPLE_BITS-1:0] yp_q [2];
  logic signed [AccW-1:0]        acc_q, acc_d;

  logic [RegIdxW-1:0]            coef_idx;
  logic signed [CoefW-1:0]       coef_op;
  logic signed [SAMPLE_BITS:0]   smp_op;
  logic signed [ProdW-1:0]       prod;
  logic signed [AccW-1:0]        prod_ext;
  logic signed [AccW-1:0]        rnd;
  logic signed [AccW-1:0]        shifted;
  logic signed [SAMPLE_BITS-1:0] sat_val;

  // Coefficient registers, written from the configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        coef_q[i] <= ((i % 4) == 0) ? CoefOne : '0;
      end
    end else if (cfg_we_i) begin
      coef_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // Select multiplier operands
  assign coef_idx = {ctrl_i.ear, ctrl_i.uw.coef};
  assign coef_op  = coef_q[coef_idx];

  always_comb begin
    case (ctrl_i.uw.opd)
      OPD_X:   smp_op = (SAMPLE_BITS+1)'(x_q);
      OPD_XP:  smp_op = (SAMPLE_BITS+1)'(xp_q[ctrl_i.ear]);
      OPD_HP:  smp_op = (SAMPLE_BITS+1)'(hp_q[ctrl_i.ear]);
      OPD_HY:  smp_op = (SAMPLE_BITS+1)'(h_q) - (SAMPLE_BITS+1)'(yp_q[ctrl_i.ear]);
      default: smp_op = '0;
    endcase
  end

  assign prod     = coef_op * smp_op;
  assign prod_ext = AccW'(prod);

  // Accumulate
  always_comb begin
    case (ctrl_i.uw.acc_op)
      ACC_LOAD: acc_d = prod_ext;
      ACC_ADD:  acc_d = acc_q + prod_ext;
      ACC_SUB:  acc_d = acc_q - prod_ext;
      ACC_HP:   acc_d = AccW'(hp_q[ctrl_i.ear]) <<< COEF_FRAC_BITS;
      default:  acc_d = acc_q;
    endcase
  end

  // Round half up, drop the fraction, saturate to the sample range
  assign rnd     = acc_q + RndHalf;
  assign shifted = rnd >>> COEF_FRAC_BITS;

  always_comb begin
    if (shifted > SatMax) begin
      sat_val = SatMax[SAMPLE_BITS-1:0];
    end else if (shifted < SatMin) begin
      sat_val = SatMin[SAMPLE_BITS-1:0];
    end else begin
      sat_val = shifted[SAMPLE_BITS-1:0];
    end
  end

  assign result_o = sat_val;

  // Working registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_x) begin
      x_q <= sample_i;
    end
    if (ctrl_i.step) begin
      acc_q <= acc_d;
      if (ctrl_i.uw.take_h) begin
        h_q <= sat_val;
      end
    end
  end

  // Filter history, cleared at reset, committed at the end of each ear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        xp_q[i] <= '0;
        hp_q[i] <= '0;
        yp_q[i] <= '0;
      end
    end else if (ctrl_i.step && ctrl_i.uw.take_y) begin
      xp_q[ctrl_i.ear] <= x_q;
      hp_q[ctrl_i.ear] <= h_q;
      yp_q[ctrl_i.ear] <= sat_val;
    end
  end

endmodule

// ===== design/head_model_binaural_panner.sv =====
// ============================================================================
// head_model_binaural_panner
// Spherical-head binaural panner: mono sample in, left and right samples out.
// ============================================================================
// Usage:
//   Input channel (in_valid_i/in_ready_o, mono_sample_i) takes one signed
//   sample per beat. Output channel (out_valid_o/out_ready_i) returns one beat
//   carrying left_sample_o and right_sample_o for every input beat, in order.
//   Each ear runs a head-shadow filter then an allpass delay stage through
//   one shared multiply-accumulate unit, stepped by a six-word program.
//   The left ear's program runs, then the right ear's, and both results are
//   loaded into the output register. A new sample is taken only once both
//   ears are done. The output register frees the sequencer: a new sample is
//   taken while the previous result still waits. If the receiver stalls, the
//   sequencer holds at its final step until the output register is free;
//   nothing is dropped. Coefficients (Q2.16, index 0..3 left b0,b1,a1,g; 4..7
//   right) are written through cfg_we_i/cfg_idx_i/cfg_data_i, by the user
//   only while the block is idle; the block does not enforce this. Reset
//   sets b0 to one, all other coefficients and all history to zero.
// ============================================================================
module head_model_binaural_panner
  import hmbp_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS    = SampleBitsDef,
  parameter int unsigned COEF_FRAC_BITS = CoefFracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [RegIdxW-1:0]            cfg_idx_i,
  input  logic [COEF_FRAC_BITS+1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] mono_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] left_sample_o,
  output logic signed [SAMPLE_BITS-1:0] right_sample_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } seq_state_e;

  seq_state_e                    state_q, state_d;
  logic [PcW-1:0]                pc_q, pc_d;
  logic                          ear_q, ear_d;
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] left_res_q;
  logic signed [SAMPLE_BITS-1:0] left_out_q, right_out_q;

  uword_t                        uw;
  dp_ctrl_t                      ctrl;
  logic                          accept;
  logic                          running;
  logic                          stall;
  logic                          advance;
  logic                          finish;
  logic signed [SAMPLE_BITS-1:0] dp_result;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign running    = (state_q == ST_RUN);

  // Fetch the control word; hold at the last step while the output is full
  assign uw      = ucode_rom(pc_q);
  assign stall   = uw.last && ear_q && out_valid_q && !out_ready_i;
  assign advance = running && !stall;
  assign finish  = advance && uw.last && ear_q;

  assign ctrl.load_x = accept;
  assign ctrl.step   = advance;
  assign ctrl.ear    = ear_q;
  assign ctrl.uw     = uw;

  // Sequencer
  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    ear_d   = ear_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RUN;
          pc_d    = '0;
          ear_d   = 1'b0;
        end
      end
      ST_RUN: begin
        if (advance) begin
          if (uw.last) begin
            pc_d = '0;
            if (ear_q) begin
              state_d = ST_IDLE;
            end else begin
              ear_d = 1'b1;
            end
          end else begin
            pc_d = pc_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
      ear_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      ear_q   <= ear_d;
    end
  end

  hmbp_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .ctrl_i     (ctrl),
    .sample_i   (mono_sample_i),
    .result_o   (dp_result)
  );

  // Hold the left result until the right ear is done, then load the output
  always_ff @(posedge clk_i) begin
    if (advance && uw.last && !ear_q) begin
      left_res_q <= dp_result;
    end
    if (finish) begin
      left_out_q  <= left_res_q;
      right_out_q <= dp_result;
    end
  end

  // Output valid: set on finish, drop when the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign left_sample_o  = left_out_q;
  assign right_sample_o = right_out_q;

endmodule
